/* hdl/stok_pkg.sv */
// ----------------------------------------------------------------------------
// stok_pkg
// shared types and constants of the source tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

    localparam logic [2:0] KIND_TEXT  = 3'd0;
    localparam logic [2:0] KIND_NAME  = 3'd1;
    localparam logic [2:0] KIND_INT   = 3'd2;
    localparam logic [2:0] KIND_FLOAT = 3'd3;
    localparam logic [2:0] KIND_SEMI  = 3'd4;
    localparam logic [2:0] KIND_DOT   = 3'd5;
    localparam logic [2:0] KIND_EQUAL = 3'd6;
    localparam logic [2:0] KIND_ERROR = 3'd7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  text_byte;
        logic [7:0]  token_length;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        malformed;
        logic        overflow;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result [MAX_RESULTS-1:0] slot;
    } t_bundle;

endpackage

`default_nettype wire

/* hdl/stok_scan.sv */
// ----------------------------------------------------------------------------
// stok_scan
// byte classification, token state and line/column counters; builds the
// results of one input word
// ----------------------------------------------------------------------------
`default_nettype none

module stok_scan #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_cmd,
    input  wire logic [7:0]       i_char_code,
    output stok_pkg::t_bundle     o_bundle
);

    localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);

    typedef enum logic [2:0] {
        M_IDLE,
        M_NAME,
        M_NUM,
        M_FRAC,
        M_DOT,
        M_HALT
    } t_mode;

    t_mode       r_mode,    n_mode;
    logic        r_has_dot, n_has_dot;
    logic        r_bad,     n_bad;
    logic        r_over,    n_over;
    logic [7:0]  r_len,     n_len;
    logic [15:0] r_line,    n_line;
    logic [15:0] r_col,     n_col;

    logic       letter, digit, skip, is_dot, is_eq, is_semi, known, open, cont;
    logic       close_a, echo, close_b, err;
    logic [2:0] close_kind, b_kind;

    assign letter  = (i_char_code >= 8'h41 && i_char_code <= 8'h5A) ||
                     (i_char_code >= 8'h61 && i_char_code <= 8'h7A);
    assign digit   = i_char_code >= 8'h30 && i_char_code <= 8'h39;
    assign skip    = i_char_code <= stok_pkg::CH_SPACE || i_char_code == stok_pkg::CH_DEL;
    assign is_dot  = i_char_code == stok_pkg::CH_DOT;
    assign is_eq   = i_char_code == stok_pkg::CH_EQUAL;
    assign is_semi = i_char_code == stok_pkg::CH_SEMI;
    assign known   = skip || letter || digit || is_dot || is_eq || is_semi;
    assign open    = r_mode == M_NAME || r_mode == M_NUM || r_mode == M_FRAC || r_mode == M_DOT;
    assign cont    = (r_mode == M_NAME && (letter || digit)) ||
                     ((r_mode == M_NUM || r_mode == M_FRAC) && digit) ||
                     (r_mode == M_NUM && is_dot) ||
                     (r_mode == M_DOT && digit);

    always_comb begin
        unique case (r_mode)
            M_NAME:  close_kind = stok_pkg::KIND_NAME;
            M_NUM:   close_kind = r_has_dot ? stok_pkg::KIND_FLOAT : stok_pkg::KIND_INT;
            M_FRAC:  close_kind = stok_pkg::KIND_FLOAT;
            M_DOT:   close_kind = stok_pkg::KIND_DOT;
            default: close_kind = stok_pkg::KIND_ERROR;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_has_dot = r_has_dot;
        n_bad     = r_bad;
        n_over    = r_over;
        n_len     = r_len;
        n_line    = r_line;
        n_col     = r_col;
        close_a   = 1'b0;
        echo      = 1'b0;
        close_b   = 1'b0;
        err       = 1'b0;
        b_kind    = is_eq ? stok_pkg::KIND_EQUAL : stok_pkg::KIND_SEMI;
        if (i_accept && r_mode != M_HALT) begin
            if (i_cmd) begin
                close_a = open;
                n_mode  = M_IDLE;
            end else if (i_char_code != stok_pkg::CH_CR) begin
                if (cont || known) begin
                    // line and column after this byte
                    if (i_char_code == stok_pkg::CH_LF) begin
                        n_col = '0;
                        if (r_line != 16'hFFFF) begin
                            n_line = r_line + 16'd1;
                        end
                    end else if (r_col != 16'hFFFF) begin
                        n_col = r_col + 16'd1;
                    end
                end
                if (cont) begin
                    echo = 1'b1;
                    if (r_len < LEN_CAP) begin
                        n_len = r_len + 8'd1;
                    end else begin
                        n_over = 1'b1;
                    end
                    if (r_mode == M_NUM && is_dot) begin
                        n_bad     = r_bad | r_has_dot;
                        n_has_dot = 1'b1;
                    end
                    if (r_mode == M_DOT) begin
                        n_mode = M_FRAC;
                    end
                end else begin
                    close_a = open;
                    if (!known) begin
                        err    = 1'b1;
                        n_mode = M_HALT;
                    end else if (skip) begin
                        n_mode = M_IDLE;
                    end else begin
                        echo      = 1'b1;
                        n_len     = 8'd1;
                        n_over    = 1'b0;
                        n_has_dot = 1'b0;
                        n_bad     = 1'b0;
                        if (letter) begin
                            n_mode = M_NAME;
                        end else if (digit) begin
                            n_mode = M_NUM;
                        end else if (is_dot) begin
                            n_mode = M_DOT;
                        end else begin
                            close_b = 1'b1;
                            n_mode  = M_IDLE;
                        end
                    end
                end
            end
        end
    end

    // pack the results of this word in order
    always_comb begin
        logic [1:0] k;
        k        = '0;
        o_bundle = '0;
        if (close_a) begin
            o_bundle.slot[k] = '{close_kind, 8'd0, r_len, r_line, r_col, r_bad, r_over};
            k = k + 2'd1;
        end
        if (err) begin
            o_bundle.slot[k] = '{stok_pkg::KIND_ERROR, 8'd0, 8'd0, r_line, r_col, 1'b0, 1'b0};
            k = k + 2'd1;
        end
        if (echo) begin
            o_bundle.slot[k] = '{stok_pkg::KIND_TEXT, i_char_code, 8'd0, n_line, n_col,
                                 1'b0, 1'b0};
            k = k + 2'd1;
        end
        if (close_b) begin
            o_bundle.slot[k] = '{b_kind, 8'd0, 8'd1, n_line, n_col, 1'b0, 1'b0};
            k = k + 2'd1;
        end
        o_bundle.count = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_has_dot <= 1'b0;
            r_bad     <= 1'b0;
            r_over    <= 1'b0;
            r_len     <= '0;
            r_line    <= '0;
            r_col     <= '0;
        end else begin
            r_mode    <= n_mode;
            r_has_dot <= n_has_dot;
            r_bad     <= n_bad;
            r_over    <= n_over;
            r_len     <= n_len;
            r_line    <= n_line;
            r_col     <= n_col;
        end
    end

endmodule

`default_nettype wire

/* hdl/stok_seq.sv */
// ----------------------------------------------------------------------------
// stok_seq
// result register; holds the results of one input word and hands them out
// one per output word
// ----------------------------------------------------------------------------
`default_nettype none

module stok_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire stok_pkg::t_bundle i_bundle,
    input  wire logic              i_take,
    output logic                   o_free,
    output logic                   o_valid,
    output logic                   o_last,
    output stok_pkg::t_result      o_result
);

    stok_pkg::t_result [stok_pkg::MAX_RESULTS-1:0] r_slot;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;

    assign o_valid  = r_cnt != 2'd0;
    assign o_last   = r_idx == r_cnt - 2'd1;
    assign o_result = r_slot[r_idx];
    assign o_free   = !o_valid || (i_take && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load && i_bundle.count != 2'd0) begin
            r_cnt <= i_bundle.count;
            r_idx <= '0;
        end else if (i_take && o_last) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_bundle.count != 2'd0) begin
            r_slot <= i_bundle.slot;
        end
    end

endmodule

`default_nettype wire

/* hdl/source_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// source_tokenizer_core
// byte-serial source tokenizer with line and column tracking
// ----------------------------------------------------------------------------
// output: first result of a byte is valid in the cycle after acceptance
// throughput: one byte per cycle while a byte gives at most one result, taken
//   at once; more results stall the input till all are taken (result register)
// reset: synchronous active low, clears token state, counters and results
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer_core #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_code
    input  wire logic        s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // text_byte, token_length, line_number,
                                             // column_number, malformed, overflow
    output logic [2:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last_of_run
);

    stok_pkg::t_bundle bundle;
    stok_pkg::t_result result;
    logic              accept;
    logic              take;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign take   = m_axis_tvalid && m_axis_tready;

    stok_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (s_axis_tuser),
        .i_char_code (s_axis_tdata),
        .o_bundle    (bundle)
    );

    stok_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_bundle (bundle),
        .i_take   (take),
        .o_free   (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_last   (m_axis_tlast),
        .o_result (result)
    );

    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {6'd0, result.overflow, result.malformed, result.column_number,
                           result.line_number, result.token_length, result.text_byte};

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == stok_pkg::KIND_ERROR) |-> m_axis_tlast)
        else $error("error result not last of its run");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && m_axis_tuser == stok_pkg::KIND_ERROR) |=> !m_axis_tvalid)
        else $error("result after halt");
`endif

endmodule

`default_nettype wire

/* dv/stok_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stok_checker
// Watches the byte and result channels of the source tokenizer. Keeps its
// own scanner state, works out the words each accepted byte should give and
// compares every result word, field by field, with the oldest one due.
// ----------------------------------------------------------------------------

module stok_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // char_code
    input  wire logic        i_s_axis_tuser,   // cmd
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [55:0] i_m_axis_tdata,   // text_byte, token_length, line_number,
                                               // column_number, malformed, overflow
    input  wire logic [2:0]  i_m_axis_tuser,   // kind
    input  wire logic        i_m_axis_tlast,   // last_of_run
    output int               o_fail_count,
    output int               o_pending
);

    localparam int MAX_TOKEN_LEN = 255;
    localparam int TOKEN_CAP = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_NAME, SCAN_NUM, SCAN_FRAC,
        SCAN_DOT, SCAN_HALT, SCAN_EQUAL, SCAN_SEMI
    } t_scan;

    typedef struct {
        stok_pkg::t_result res;
        logic              last;
    } t_due;

    t_scan       scan;
    logic        num_dot;
    logic        num_bad;
    logic        tok_over;
    logic [7:0]  tok_len;
    logic [15:0] line_cnt;
    logic [15:0] col_cnt;
    t_due        words_due[$];
    t_due        got;
    int          fail_count = 0;

    function void clear_scan();
        scan     = SCAN_IDLE;
        num_dot  = 1'b0;
        num_bad  = 1'b0;
        tok_over = 1'b0;
        tok_len  = '0;
        line_cnt = '0;
        col_cnt  = '0;
        words_due.delete();
    endfunction

    function void due_word(logic [2:0] kind, logic [7:0] ch, logic [7:0] len,
                           logic bad, logic ovf);
        t_due w;
        w.res.kind          = kind;
        w.res.text_byte     = ch;
        w.res.token_length  = len;
        w.res.line_number   = line_cnt;
        w.res.column_number = col_cnt;
        w.res.malformed     = bad;
        w.res.overflow      = ovf;
        w.last              = 1'b0;
        words_due.push_back(w);
    endfunction

    function void count_char(logic [7:0] ch);
        if (ch == stok_pkg::CH_LF) begin
            col_cnt = '0;
            if (line_cnt != 16'hFFFF) line_cnt++;
        end else if (col_cnt != 16'hFFFF) begin
            col_cnt++;
        end
    endfunction

    function void open_token(t_scan mode);
        scan     = mode;
        tok_len  = '0;
        num_dot  = 1'b0;
        num_bad  = 1'b0;
        tok_over = 1'b0;
    endfunction

    function void echo_char(logic [7:0] ch);
        if (tok_len < TOKEN_CAP) tok_len++;
        else tok_over = 1'b1;
        due_word(stok_pkg::KIND_TEXT, ch, '0, 1'b0, 1'b0);
    endfunction

    function void close_token();
        logic [2:0] kind;
        case (scan)
            SCAN_NAME:  kind = stok_pkg::KIND_NAME;
            SCAN_NUM:   kind = num_dot ? stok_pkg::KIND_FLOAT : stok_pkg::KIND_INT;
            SCAN_FRAC:  kind = stok_pkg::KIND_FLOAT;
            SCAN_DOT:   kind = stok_pkg::KIND_DOT;
            SCAN_EQUAL: kind = stok_pkg::KIND_EQUAL;
            SCAN_SEMI:  kind = stok_pkg::KIND_SEMI;
            default:    return;
        endcase
        due_word(kind, '0, tok_len, num_bad, tok_over);
        scan = SCAN_IDLE;
    endfunction

    function void scan_byte(logic cmd, logic [7:0] ch);
        int   n_prior;
        logic is_letter;
        logic is_digit;
        logic is_skip;
        t_due w;
        n_prior   = words_due.size();
        is_letter = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
        is_digit  = ch >= "0" && ch <= "9";
        is_skip   = ch <= stok_pkg::CH_SPACE || ch == stok_pkg::CH_DEL;
        if (scan == SCAN_HALT) return;
        if (cmd) begin
            close_token();
        end else if (ch != stok_pkg::CH_CR) begin
            if ((scan == SCAN_NAME && (is_letter || is_digit)) ||
                ((scan == SCAN_NUM || scan == SCAN_FRAC) && is_digit)) begin
                count_char(ch);
                echo_char(ch);
            end else if (scan == SCAN_NUM && ch == stok_pkg::CH_DOT) begin
                if (num_dot) num_bad = 1'b1;
                num_dot = 1'b1;
                count_char(ch);
                echo_char(ch);
            end else if (scan == SCAN_DOT && is_digit) begin
                scan = SCAN_FRAC;
                count_char(ch);
                echo_char(ch);
            end else begin
                close_token();
                if (!(is_skip || is_letter || is_digit || ch == stok_pkg::CH_DOT ||
                      ch == stok_pkg::CH_EQUAL || ch == stok_pkg::CH_SEMI)) begin
                    due_word(stok_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0);
                    scan = SCAN_HALT;
                end else begin
                    count_char(ch);
                    if (!is_skip) begin
                        if (is_letter) open_token(SCAN_NAME);
                        else if (is_digit) open_token(SCAN_NUM);
                        else if (ch == stok_pkg::CH_DOT) open_token(SCAN_DOT);
                        else if (ch == stok_pkg::CH_EQUAL) open_token(SCAN_EQUAL);
                        else open_token(SCAN_SEMI);
                        echo_char(ch);
                        if (scan == SCAN_EQUAL || scan == SCAN_SEMI) close_token();
                    end
                end
            end
        end
        if (words_due.size() > n_prior) begin
            w = words_due.pop_back();
            w.last = 1'b1;
            words_due.push_back(w);
        end
    endfunction

    function void check_field(string what, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (words_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: word with none due, expected nothing, %s %0d data %h",
                             $time, "actual kind", i_m_axis_tuser, i_m_axis_tdata);
                end else begin
                    got = words_due.pop_front();
                    check_field("kind", got.res.kind, i_m_axis_tuser);
                    check_field("text_byte", got.res.text_byte, i_m_axis_tdata[7:0]);
                    check_field("token_length", got.res.token_length, i_m_axis_tdata[15:8]);
                    check_field("line_number", got.res.line_number, i_m_axis_tdata[31:16]);
                    check_field("column_number", got.res.column_number,
                                i_m_axis_tdata[47:32]);
                    check_field("malformed", got.res.malformed, i_m_axis_tdata[48]);
                    check_field("overflow", got.res.overflow, i_m_axis_tdata[49]);
                    check_field("last_of_run", got.last, i_m_axis_tlast);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                scan_byte(i_s_axis_tuser, i_s_axis_tdata);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= words_due.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Feeds the source tokenizer a directed opening, random well-formed token
// streams with some noise and a final unknown byte with input after the
// halt. Both sides idle and stall at random; a separate checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------

module tb;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // char_code
    logic        s_axis_tuser = 1'b0;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // text_byte, token_length, line_number,
                                        // column_number, malformed, overflow
    logic [2:0]  m_axis_tuser;          // kind
    logic        m_axis_tlast;          // last_of_run

    int fail_count;
    int words_pending;
    int words_sent = 0;
    bit steady   = 1'b0;
    bit rx_hold  = 1'b0;
    bit hold_req = 1'b0;

    source_tokenizer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    stok_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (words_pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (rx_hold) m_axis_tready <= 1'b0;
        else if (steady) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 99) >= 13);
    end

    // long receiver hold-off so the block backs up onto its input
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (40) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #(2_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1)) return 8'("A" + $urandom_range(0, 25));
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_skip();
        if ($urandom_range(0, 9) == 0) return stok_pkg::CH_DEL;
        return 8'($urandom_range(0, 32));
    endfunction

    function automatic logic [7:0] rand_token_byte();
        case ($urandom_range(0, 6))
            0:       return rand_letter();
            1:       return rand_digit();
            2:       return stok_pkg::CH_DOT;
            3:       return stok_pkg::CH_EQUAL;
            4:       return stok_pkg::CH_SEMI;
            5:       return stok_pkg::CH_CR;
            default: return rand_skip();
        endcase
    endfunction

    task automatic offer_word(input logic cmd, input logic [7:0] ch);
        while (!steady && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= cmd ? 8'($urandom_range(0, 255)) : ch;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic offer_text(input string s);
        for (int i = 0; i < s.len(); i++) offer_word(1'b0, s[i]);
    endtask

    task automatic offer_end();
        offer_word(1'b1, 8'h00);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    task automatic offer_random_token();
        int n;
        case ($urandom_range(0, 9))
            0, 1: begin
                offer_word(1'b0, rand_letter());
                n = $urandom_range(0, 5);
                repeat (n) begin
                    offer_word(1'b0, $urandom_range(0, 2) ? rand_letter() : rand_digit());
                end
            end
            2, 3: begin
                n = $urandom_range(1, 4);
                repeat (n) offer_word(1'b0, rand_digit());
                if ($urandom_range(0, 1)) begin
                    offer_word(1'b0, stok_pkg::CH_DOT);
                    n = $urandom_range(0, 3);
                    repeat (n) offer_word(1'b0, rand_digit());
                    if ($urandom_range(0, 5) == 0) begin
                        offer_word(1'b0, stok_pkg::CH_DOT);
                        n = $urandom_range(0, 2);
                        repeat (n) offer_word(1'b0, rand_digit());
                    end
                end
            end
            4: begin
                offer_word(1'b0, stok_pkg::CH_DOT);
                n = $urandom_range(0, 3);
                repeat (n) offer_word(1'b0, rand_digit());
            end
            5: offer_word(1'b0, stok_pkg::CH_EQUAL);
            6: offer_word(1'b0, stok_pkg::CH_SEMI);
            7: offer_end();
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) offer_word(1'b0, rand_token_byte());
            end
        endcase
        if ($urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 3))
                0: offer_word(1'b0, stok_pkg::CH_SPACE);
                1: offer_word(1'b0, stok_pkg::CH_LF);
                2: begin
                    offer_word(1'b0, stok_pkg::CH_CR);
                    offer_word(1'b0, stok_pkg::CH_LF);
                end
                default: offer_word(1'b0, rand_skip());
            endcase
        end
    endtask

    initial begin
        int         base;
        bit         paused;
        string      punct;
        logic [7:0] odd_ch;
        paused = 1'b0;
        punct  = "!\"#$%&'()*+,-/:<>?@[\\]^_`{|}~";
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // names, equal, semicolon, second dot, dot-led float split by a dot,
        // held dot across a dropped carriage return, end of input cases
        offer_text("a9Z=;1.2.3 .5.6 .");
        offer_word(1'b0, stok_pkg::CH_CR);
        offer_word(1'b0, stok_pkg::CH_LF);
        offer_text("x");
        offer_end();
        offer_text("4.");
        offer_end();
        offer_word(1'b0, 8'h00);
        offer_text(".");
        offer_end();
        offer_end();
        offer_word(1'b0, stok_pkg::CH_DEL);
        offer_text(".q;");

        base = words_sent;
        while (words_sent - base < 130) begin
            steady <= (words_sent - base >= 50) && (words_sent - base < 90);
            if (words_sent - base >= 20) hold_req <= 1'b1;
            if (words_sent - base >= 100 && !paused) begin
                paused = 1'b1;
                wait_drained();
            end
            offer_random_token();
        end
        steady <= 1'b0;
        repeat (8) offer_random_token();

        // unknown byte closes the open token, then the block stays halted
        offer_text("k");
        if ($urandom_range(0, 1)) odd_ch = 8'($urandom_range(128, 255));
        else odd_ch = punct[$urandom_range(0, punct.len() - 1)];
        offer_word(1'b0, odd_ch);
        offer_word(1'b0, 8'hFF);
        offer_word(1'b0, 8'h80);
        offer_end();
        repeat (6) offer_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
